// File: rtl/gnf_pkg.sv
// ----------------------------------------------------------------------------
// gnf_pkg: shared types and constants for the grammar norm fixpoint block
// defaults for the parameters and the sequencer state encoding
// ----------------------------------------------------------------------------
package gnf_pkg;
   localparam int MAX_SYMBOLS_DEF     = 64;
   localparam int MAX_PRODUCTIONS_DEF = 64;
   localparam int MAX_BODY_DEF        = 8;
   localparam int NORM_BITS_DEF       = 16;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PROD,
      ST_BODY,
      ST_UPDATE,
      ST_EMIT_RD,
      ST_EMIT_HEAD,
      ST_EMIT
   } state_type;
endpackage

// File: rtl/gnf_accum.sv
// ----------------------------------------------------------------------------
// gnf_accum: shared saturating norm adder
// adds one body symbol norm a cycle, while add is high, into the running production sum
// ----------------------------------------------------------------------------
module gnf_accum #(
   parameter int NORM_BITS = 16
) (
   input  logic                 clock,
   input  logic                 init,
   input  logic                 add,
   input  logic [NORM_BITS-1:0] operand,
   output logic [NORM_BITS-1:0] sum,
   output logic                 undef
);
   logic [NORM_BITS-1:0] sum_ff, sum_in;
   logic                 undef_ff, undef_in;
   logic [NORM_BITS:0]   wide;

   assign wide = {1'b0, sum_ff} + {1'b0, operand};

   always_comb begin
      sum_in   = sum_ff;
      undef_in = undef_ff;
      if (init) begin
         sum_in   = NORM_BITS'(1);
         undef_in = 1'b0;
      end else if (add) begin
         if (operand == '0) begin
            undef_in = 1'b1;
         end
         sum_in = wide[NORM_BITS] ? '1 : wide[NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      undef_ff <= undef_in;
   end

   assign sum   = sum_ff;
   assign undef = undef_ff;
endmodule

// File: rtl/grammar_norm_fixpoint.sv
// ----------------------------------------------------------------------------
// grammar_norm_fixpoint: norms of a stored grammar by repeated passes
// loads productions, then iterates to a fixpoint and reports each production
// ----------------------------------------------------------------------------
// a load leaves busy low; a compute on an empty grammar returns nothing;
// otherwise a compute clears MAX_SYMBOLS norms, then each pass reads every
// production and sums its body norms on the shared adder, repeated until a pass
// changes nothing, then reads and emits each result in turn; the receiver
// cannot stall. synchronous reset clears the production count and the sequencer.
module grammar_norm_fixpoint #(
   parameter int MAX_SYMBOLS     = gnf_pkg::MAX_SYMBOLS_DEF,
   parameter int MAX_PRODUCTIONS = gnf_pkg::MAX_PRODUCTIONS_DEF,
   parameter int MAX_BODY        = gnf_pkg::MAX_BODY_DEF,
   parameter int NORM_BITS       = gnf_pkg::NORM_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [5:0]  req_lhs,
   input  logic [3:0]  req_rhs_count,
   input  logic [5:0]  req_rhs_0,
   input  logic [5:0]  req_rhs_1,
   input  logic [5:0]  req_rhs_2,
   input  logic [5:0]  req_rhs_3,
   input  logic [5:0]  req_rhs_4,
   input  logic [5:0]  req_rhs_5,
   input  logic [5:0]  req_rhs_6,
   input  logic [5:0]  req_rhs_7,
   output logic        rsp_valid,
   output logic [5:0]  rsp_production_index,
   output logic [5:0]  rsp_head_symbol,
   output logic [15:0] rsp_production_norm,
   output logic [15:0] rsp_head_norm,
   output logic        rsp_is_normed,
   output logic        rsp_last
);
   import gnf_pkg::*;

   localparam int PB = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;
   localparam int CB = $clog2(MAX_PRODUCTIONS + 1);
   localparam int SB = $clog2(MAX_SYMBOLS);
   localparam int BB = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
   localparam int LB = $clog2(MAX_BODY + 1);

   logic [5:0]            heads_mem [MAX_PRODUCTIONS];
   logic [LB-1:0]         lens_mem  [MAX_PRODUCTIONS];
   logic [MAX_BODY*6-1:0] body_mem  [MAX_PRODUCTIONS];
   logic [NORM_BITS-1:0]  sym_mem   [MAX_SYMBOLS];
   logic [NORM_BITS-1:0]  pn_mem    [MAX_PRODUCTIONS];

   state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [PB-1:0] prod_ff, prod_in;
   logic [BB:0]   pos_ff, pos_in;
   logic [SB:0]   clr_ff, clr_in;
   logic          changed_ff, changed_in;

   logic [5:0]            head_rd;
   logic [LB-1:0]         len_rd;
   logic [5:0]            body_rd;
   logic [MAX_BODY*6-1:0] body_wr, body_word_rd;
   logic [5:0]            body_sel;
   logic [NORM_BITS-1:0]  sym_rd, pn_rd;
   logic                  sym_ok_ff;

   logic [NORM_BITS-1:0] acc_sum;
   logic                 acc_undef, acc_init, acc_add;
   logic [NORM_BITS-1:0] pnorm;

   logic accept, do_load, last_prod, body_done;
   logic [LB-1:0] load_len;
   logic [5:0] rhs [8];

   assign rhs = '{req_rhs_0, req_rhs_1, req_rhs_2, req_rhs_3,
                  req_rhs_4, req_rhs_5, req_rhs_6, req_rhs_7};
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign do_load = accept && req_kind == KIND_LOAD
                    && count_ff < CB'(MAX_PRODUCTIONS)
                    && 32'(req_lhs) < MAX_SYMBOLS;
   assign load_len = (32'(req_rhs_count) > MAX_BODY) ? LB'(MAX_BODY)
                                                      : LB'(req_rhs_count);
   assign last_prod = (CB'(prod_ff) + CB'(1) == count_ff);
   assign pnorm = acc_undef ? '0 : acc_sum;
   // last body cycle: the final symbol norm is being added
   assign body_done = (LB+1)'(pos_ff) >= (LB+1)'(len_rd) + (LB+1)'(1);

   always_comb begin
      for (int i = 0; i < MAX_BODY; i++) begin
         body_wr[i*6 +: 6] = rhs[i];
      end
   end

   always_comb begin
      body_sel = '0;
      for (int i = 0; i < MAX_BODY; i++) begin
         if (32'(pos_ff) == i) begin
            body_sel = body_word_rd[i*6 +: 6];
         end
      end
   end

   // production stores and body symbol read
   always_ff @(posedge clock) begin
      if (do_load) begin
         heads_mem[count_ff[PB-1:0]] <= req_lhs;
         lens_mem[count_ff[PB-1:0]]  <= load_len;
         body_mem[count_ff[PB-1:0]]  <= body_wr;
      end
      head_rd      <= heads_mem[prod_ff];
      len_rd       <= lens_mem[prod_ff];
      body_word_rd <= body_mem[prod_ff];
      body_rd      <= body_sel;
   end

   // symbol norm memory: read by body symbol or head, written by update/clear
   logic [SB-1:0] sym_addr;
   logic          sym_we;
   logic [NORM_BITS-1:0] sym_wd;
   logic          body_sym_ok;
   assign body_sym_ok = 32'(body_rd) < MAX_SYMBOLS;
   always_comb begin
      sym_addr = SB'(body_rd);
      if (state_ff == ST_UPDATE || state_ff == ST_EMIT_RD || state_ff == ST_PROD
          || state_ff == ST_EMIT_HEAD || (state_ff == ST_BODY && body_done)) begin
         sym_addr = SB'(head_rd);
      end
   end
   logic update_hit;
   assign update_hit = state_ff == ST_UPDATE && pnorm != '0
                       && (sym_rd == '0 || pnorm < sym_rd);
   always_comb begin
      sym_we = 1'b0;
      sym_wd = pnorm;
      if (state_ff == ST_CLEAR) begin
         sym_we = 1'b1;
         sym_wd = '0;
      end else if (update_hit) begin
         sym_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[state_ff == ST_CLEAR ? clr_ff[SB-1:0] : SB'(head_rd)] <= sym_wd;
      end
      sym_rd    <= sym_mem[sym_addr];
      sym_ok_ff <= body_sym_ok;
      if (state_ff == ST_UPDATE) begin
         pn_mem[prod_ff] <= pnorm;
      end
      pn_rd <= pn_mem[prod_ff];
   end

   gnf_accum #(.NORM_BITS(NORM_BITS)) u_accum (
      .clock   (clock),
      .init    (acc_init),
      .add     (acc_add),
      .operand (sym_ok_ff ? sym_rd : '0),
      .sum     (acc_sum),
      .undef   (acc_undef)
   );

   // next state
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      prod_in    = prod_ff;
      pos_in     = pos_ff;
      clr_in     = clr_ff;
      changed_in = changed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_load) begin
               count_in = count_ff + CB'(1);
            end
            if (accept && req_kind == KIND_COMPUTE && count_ff != '0) begin
               state_in = ST_CLEAR;
               clr_in   = '0;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + (SB+1)'(1);
            if (32'(clr_ff) == MAX_SYMBOLS - 1) begin
               state_in   = ST_PROD;
               prod_in    = '0;
               changed_in = 1'b0;
            end
         end
         ST_PROD: begin
            // head, length and body word land at the end of this cycle
            state_in = ST_BODY;
            pos_in   = '0;
         end
         ST_BODY: begin
            // symbol pos-1 is registered, the norm of symbol pos-2 is added
            pos_in = pos_ff + (BB+1)'(1);
            if (body_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (update_hit) begin
               changed_in = 1'b1;
            end
            if (last_prod) begin
               prod_in = '0;
               if (changed_ff || update_hit) begin
                  state_in   = ST_PROD;
                  changed_in = 1'b0;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end else begin
               prod_in  = prod_ff + PB'(1);
               state_in = ST_PROD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_HEAD;
         end
         ST_EMIT_HEAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (last_prod) begin
               state_in = ST_IDLE;
            end else begin
               prod_in  = prod_ff + PB'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      acc_init = 1'b0;
      acc_add  = 1'b0;
      case (state_ff)
         ST_PROD: acc_init = 1'b1;
         ST_BODY: acc_add  = ((LB+1)'(pos_ff) >= (LB+1)'(2))
                             && ((LB+1)'(pos_ff) <= (LB+1)'(len_rd) + (LB+1)'(1));
         ST_UPDATE: acc_add = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         prod_ff    <= '0;
         pos_ff     <= '0;
         clr_ff     <= '0;
         changed_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         prod_ff    <= prod_in;
         pos_ff     <= pos_in;
         clr_ff     <= clr_in;
         changed_ff <= changed_in;
      end
   end

   logic [NORM_BITS-1:0] hn;
   assign hn = sym_rd;
   assign rsp_valid            = (state_ff == ST_EMIT) && !reset;
   assign rsp_production_index = 6'(prod_ff);
   assign rsp_head_symbol      = head_rd;
   assign rsp_production_norm  = 16'(pn_rd);
   assign rsp_head_norm        = 16'(hn);
   assign rsp_is_normed        = (pn_rd != '0) && (pn_rd == hn);
   assign rsp_last             = last_prod;
endmodule
